### src/apsp_pkg.sv
// Shared types and constants of the all-pairs shortest path block.
// Used by apsp_regs, apsp_ctrl, apsp_dpath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package apsp_pkg;

    // Item field widths.
    localparam int OP_W         = 2;
    localparam int NODE_FIELD_W = 6;
    localparam int WEIGHT_W     = 16;
    localparam int DISTANCE_W   = 16;

    // Stream packing: src, dst, weight from the lowest bit up.
    localparam int SRC_LSB    = 0;
    localparam int DST_LSB    = SRC_LSB + NODE_FIELD_W;
    localparam int WEIGHT_LSB = DST_LSB + NODE_FIELD_W;
    localparam int S_TDATA_W  = 32;
    localparam int S_TUSER_W  = OP_W;
    localparam int M_TDATA_W  = DISTANCE_W;
    localparam int M_TUSER_W  = 2;

    // Register file.
    localparam int NODE_COUNT_W = 7;
    localparam int INF_W        = 16;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;
    localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = 7'd64;
    localparam logic [INF_W-1:0]        INF_RESET        = 16'd1000;

    typedef enum logic
    {
        REG_NODE_COUNT = 1'b0,
        REG_INF_VALUE  = 1'b1
    } reg_idx_t;

    typedef enum logic [OP_W-1:0]
    {
        OP_CLEAR = 2'd0,
        OP_EDGE  = 2'd1,
        OP_SOLVE = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    // Memory operation issued by the controller for the current cycle.
    typedef enum logic [2:0]
    {
        MEM_IDLE     = 3'd0,
        MEM_CLEAR_WR = 3'd1,
        MEM_EDGE_WR  = 3'd2,
        MEM_RD_ITEM  = 3'd3,
        MEM_RD_PIVOT = 3'd4,
        MEM_RD_CELL  = 3'd5,
        MEM_RELAX    = 3'd6
    } mem_cmd_t;

    typedef struct packed
    {
        logic     load_item;
        logic     cnt_clr;
        logic     cnt_adv;
        logic     cnt_full;   // sweep the whole store instead of the nodes in use
        mem_cmd_t mem_cmd;
        logic     load_dik;
        logic     post;
    } dp_cmd_t;

    typedef struct packed
    {
        logic j_last;
        logic i_last;
        logic k_last;
        logic n_zero;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

### src/apsp_regs.sv
// APB register file: node_count and inf_value.
// Depends on apsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module apsp_regs
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [apsp_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire logic [apsp_pkg::APB_DATA_W-1:0]      pwdata,
    output logic      [apsp_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                      pready,
    output logic      [apsp_pkg::NODE_COUNT_W-1:0]    node_count,
    output logic      [apsp_pkg::INF_W-1:0]           inf_value
);

    logic [apsp_pkg::NODE_COUNT_W-1:0] node_count_reg;
    logic [apsp_pkg::INF_W-1:0]        inf_value_reg;
    apsp_pkg::reg_idx_t                reg_idx;
    logic                              wr_en;

    assign pready  = 1'b1;
    assign reg_idx = apsp_pkg::reg_idx_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= apsp_pkg::NODE_COUNT_RESET;
            inf_value_reg  <= apsp_pkg::INF_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                apsp_pkg::REG_NODE_COUNT: node_count_reg <= pwdata[apsp_pkg::NODE_COUNT_W-1:0];
                apsp_pkg::REG_INF_VALUE:  inf_value_reg  <= pwdata[apsp_pkg::INF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            apsp_pkg::REG_NODE_COUNT: prdata = apsp_pkg::APB_DATA_W'(node_count_reg);
            apsp_pkg::REG_INF_VALUE:  prdata = apsp_pkg::APB_DATA_W'(inf_value_reg);
            default:                  prdata = '0;
        endcase
    end

    assign node_count = node_count_reg;
    assign inf_value  = inf_value_reg;

endmodule

`default_nettype wire

### src/apsp_ctrl.sv
// Controller FSM: sequences clear sweep, edge write, read and the k,i,j solve.
// Depends on apsp_pkg; drives apsp_dpath through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module apsp_ctrl
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire apsp_pkg::op_t        in_op,
    input  wire apsp_pkg::dp_status_t status,
    output apsp_pkg::dp_cmd_t         cmd
);

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_CLEAR,
        S_EDGE,
        S_READ,
        S_PIVOT,
        S_LOAD,
        S_CELL_RD,
        S_CELL_WR,
        S_POST
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;
    logic   accept;

    assign accept   = in_valid && ready_reg;
    assign in_ready = ready_reg;

    always_comb
    begin
        state_next    = state_reg;
        ready_next    = ready_reg;
        cmd.load_item = 1'b0;
        cmd.cnt_clr   = 1'b0;
        cmd.cnt_adv   = 1'b0;
        cmd.cnt_full  = 1'b0;
        cmd.mem_cmd   = apsp_pkg::MEM_IDLE;
        cmd.load_dik  = 1'b0;
        cmd.post      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_item = 1'b1;
                    cmd.cnt_clr   = 1'b1;
                    ready_next    = 1'b0;
                    case (in_op)
                        apsp_pkg::OP_CLEAR: state_next = S_CLEAR;
                        apsp_pkg::OP_EDGE:  state_next = S_EDGE;
                        apsp_pkg::OP_SOLVE: state_next = status.n_zero ? S_POST : S_PIVOT;
                        apsp_pkg::OP_READ:  state_next = S_READ;
                        default:            state_next = S_POST;
                    endcase
                end
            end
            S_CLEAR:
            begin
                cmd.mem_cmd  = apsp_pkg::MEM_CLEAR_WR;
                cmd.cnt_adv  = 1'b1;
                cmd.cnt_full = 1'b1;
                if (status.j_last && status.i_last)
                begin
                    state_next = S_POST;
                end
            end
            S_EDGE:
            begin
                cmd.mem_cmd = apsp_pkg::MEM_EDGE_WR;
                state_next  = S_POST;
            end
            S_READ:
            begin
                cmd.mem_cmd = apsp_pkg::MEM_RD_ITEM;
                state_next  = S_POST;
            end
            S_PIVOT:
            begin
                cmd.mem_cmd = apsp_pkg::MEM_RD_PIVOT;
                state_next  = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.load_dik = 1'b1;
                cmd.mem_cmd  = apsp_pkg::MEM_RD_CELL;
                state_next   = S_CELL_WR;
            end
            S_CELL_RD:
            begin
                cmd.mem_cmd = apsp_pkg::MEM_RD_CELL;
                state_next  = S_CELL_WR;
            end
            S_CELL_WR:
            begin
                cmd.mem_cmd = apsp_pkg::MEM_RELAX;
                cmd.cnt_adv = 1'b1;
                if (!status.j_last)
                begin
                    state_next = S_CELL_RD;
                end
                else if (status.i_last && status.k_last)
                begin
                    state_next = S_POST;
                end
                else
                begin
                    state_next = S_PIVOT;
                end
            end
            S_POST:
            begin
                if (status.out_free)
                begin
                    cmd.post    = 1'b1;
                    cmd.cnt_clr = 1'b1;
                    ready_next  = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

endmodule

`default_nettype wire

### src/apsp_dpath.sv
// Datapath: distance memory (1 write, 2 registered reads), loop counters,
// relax adder/compare and the output register. Depends on apsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module apsp_dpath
#(
    parameter int MAX_NODES  = 64,
    parameter int DIST_WIDTH = 16
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire apsp_pkg::dp_cmd_t                    cmd,
    output apsp_pkg::dp_status_t                      status,
    input  wire logic [apsp_pkg::NODE_COUNT_W-1:0]    node_count,
    input  wire logic [apsp_pkg::INF_W-1:0]           inf_value,
    input  wire apsp_pkg::op_t                        in_op,
    input  wire logic [apsp_pkg::NODE_FIELD_W-1:0]    in_src,
    input  wire logic [apsp_pkg::NODE_FIELD_W-1:0]    in_dst,
    input  wire logic [apsp_pkg::WEIGHT_W-1:0]        in_weight,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic      [apsp_pkg::DISTANCE_W-1:0]      out_distance,
    output logic                                      out_is_inf,
    output logic                                      out_done
);

    localparam int IDX_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam logic [DIST_WIDTH-1:0] DIST_MAX = '1;

    // Item registers
    apsp_pkg::op_t                     op_reg;
    logic [apsp_pkg::NODE_FIELD_W-1:0] src_reg;
    logic [apsp_pkg::NODE_FIELD_W-1:0] dst_reg;
    logic [apsp_pkg::WEIGHT_W-1:0]     weight_reg;

    // Loop counters: pivot k, row i, column j
    logic [IDX_W-1:0] k_reg, i_reg, j_reg;

    logic [DIST_WIDTH-1:0] mem [0:DEPTH-1];
    logic [DIST_WIDTH-1:0] rd_a_reg, rd_b_reg, dik_reg;

    logic                      out_valid_reg;
    logic [apsp_pkg::DISTANCE_W-1:0] out_dist_reg;
    logic                      out_inf_reg;
    logic                      out_done_reg;

    logic [CNT_W-1:0]      n_use, bound;
    logic [DIST_WIDTH-1:0] inf_use;
    logic [IDX_W-1:0]      src_idx, dst_idx;
    logic                  src_in, dst_in, edge_ok;
    logic [DIST_WIDTH-1:0] edge_val;
    logic [DIST_WIDTH:0]   via;
    logic                  j_last, i_last, k_last;
    logic                  we, ren_a, ren_b;
    logic [ADDR_W-1:0]     waddr, raddr_a, raddr_b;
    logic [DIST_WIDTH-1:0] wdata;
    logic [DIST_WIDTH-1:0] read_dist;
    logic                  out_free;

    // Effective configuration
    assign n_use   = (32'(node_count) > 32'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                        : CNT_W'(node_count);
    assign inf_use = (32'(inf_value) > 32'(DIST_MAX)) ? DIST_MAX : DIST_WIDTH'(inf_value);

    assign src_idx  = IDX_W'(src_reg);
    assign dst_idx  = IDX_W'(dst_reg);
    assign src_in   = 32'(src_reg) < 32'(n_use);
    assign dst_in   = 32'(dst_reg) < 32'(n_use);
    assign edge_ok  = src_in && dst_in && (src_reg != dst_reg);
    assign edge_val = (32'(weight_reg) > 32'(inf_use)) ? inf_use : DIST_WIDTH'(weight_reg);

    // Counter wrap points
    assign bound  = cmd.cnt_full ? CNT_W'(MAX_NODES) : n_use;
    assign j_last = (CNT_W'(j_reg) + CNT_W'(1)) == bound;
    assign i_last = (CNT_W'(i_reg) + CNT_W'(1)) == bound;
    assign k_last = (CNT_W'(k_reg) + CNT_W'(1)) == bound;

    // d[i][k] + d[k][j], one bit wider so it cannot wrap
    assign via = {1'b0, dik_reg} + {1'b0, rd_a_reg};

    always_comb
    begin
        we      = 1'b0;
        ren_a   = 1'b0;
        ren_b   = 1'b0;
        waddr   = {i_reg, j_reg};
        wdata   = '0;
        raddr_a = {i_reg, k_reg};
        raddr_b = {i_reg, j_reg};
        case (cmd.mem_cmd)
            apsp_pkg::MEM_CLEAR_WR:
            begin
                we    = 1'b1;
                wdata = (i_reg == j_reg) ? '0 : inf_use;
            end
            apsp_pkg::MEM_EDGE_WR:
            begin
                we    = edge_ok;
                waddr = {src_idx, dst_idx};
                wdata = edge_val;
            end
            apsp_pkg::MEM_RD_ITEM:
            begin
                ren_a   = 1'b1;
                raddr_a = {src_idx, dst_idx};
            end
            apsp_pkg::MEM_RD_PIVOT:
            begin
                ren_a = 1'b1;
            end
            apsp_pkg::MEM_RD_CELL:
            begin
                ren_a   = 1'b1;
                ren_b   = 1'b1;
                raddr_a = {k_reg, j_reg};
            end
            apsp_pkg::MEM_RELAX:
            begin
                we    = via < {1'b0, rd_b_reg};
                wdata = via[DIST_WIDTH-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (ren_a)
        begin
            rd_a_reg <= mem[raddr_a];
        end
        if (ren_b)
        begin
            rd_b_reg <= mem[raddr_b];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg     <= in_op;
            src_reg    <= in_src;
            dst_reg    <= in_dst;
            weight_reg <= in_weight;
        end
        if (cmd.load_dik)
        begin
            dik_reg <= rd_a_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= '0;
            i_reg <= '0;
            j_reg <= '0;
        end
        else if (cmd.cnt_clr)
        begin
            k_reg <= '0;
            i_reg <= '0;
            j_reg <= '0;
        end
        else if (cmd.cnt_adv)
        begin
            if (!j_last)
            begin
                j_reg <= j_reg + IDX_W'(1);
            end
            else
            begin
                j_reg <= '0;
                if (!i_last)
                begin
                    i_reg <= i_reg + IDX_W'(1);
                end
                else
                begin
                    i_reg <= '0;
                    k_reg <= k_last ? '0 : k_reg + IDX_W'(1);
                end
            end
        end
    end

    // Result; rd_a_reg still holds the read entry in the post cycle
    assign read_dist = (src_in && dst_in) ? rd_a_reg : inf_use;
    assign out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.post)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.post)
        begin
            if (op_reg == apsp_pkg::OP_READ)
            begin
                out_dist_reg <= apsp_pkg::DISTANCE_W'(read_dist);
                out_inf_reg  <= read_dist == inf_use;
            end
            else
            begin
                out_dist_reg <= '0;
                out_inf_reg  <= 1'b0;
            end
            out_done_reg <= 1'b1;
        end
    end

    assign status.j_last   = j_last;
    assign status.i_last   = i_last;
    assign status.k_last   = k_last;
    assign status.n_zero   = n_use == '0;
    assign status.out_free = out_free;

    assign out_valid    = out_valid_reg;
    assign out_distance = out_dist_reg;
    assign out_is_inf   = out_inf_reg;
    assign out_done     = out_done_reg;

endmodule

`default_nettype wire

### src/all_pairs_shortest_path_top.sv
// Top level of the all-pairs shortest path (Floyd-Warshall) block.
// Depends on apsp_pkg, apsp_regs, apsp_ctrl and apsp_dpath.
`timescale 1ns / 1ps
`default_nettype none

// All-pairs shortest path engine. A distance matrix of MAX_NODES x MAX_NODES
// entries lives in one on-chip RAM (one write port, two registered read
// ports). Each input item carries an opcode in s_axis_tuser and gives exactly
// one result item: clear fills the whole store with inf_value and 0 on the
// diagonal; edge writes one weight (capped at inf_value, ignored for
// self-loops or nodes not in use); solve runs the k,i,j relaxation in place;
// read returns one distance with an infinity flag. One item is in work at a
// time, but a new item is taken while the previous result still sits in the
// output register. The single RAM write port and the read-then-relax step of
// the controller set the pace of each item:
//   edge or read  : one memory access
//   clear         : the whole store, one entry a cycle
//   solve         : n = node_count capped at MAX_NODES; per row one
//                   pivot-column read, then a read and a relax per cell
// Distances are DIST_WIDTH bits internally; sums are formed one bit wider.
// Reading the matrix before the first clear returns undefined data.
// Registers (APB, 32-bit): 0x0 node_count (reset 64), 0x4 inf_value (reset 1000).
module all_pairs_shortest_path_top
#(
    parameter int MAX_NODES  = 64,
    parameter int DIST_WIDTH = 16
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // APB configuration port
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [apsp_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire logic [apsp_pkg::APB_DATA_W-1:0]      pwdata,
    output logic      [apsp_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                      pready,
    // Input items
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // [5:0] src_node, [11:6] dst_node, [27:12] edge_weight, [31:28] zero
    input  wire logic [apsp_pkg::S_TDATA_W-1:0]       s_axis_tdata,
    // [1:0] opcode
    input  wire logic [apsp_pkg::S_TUSER_W-1:0]       s_axis_tuser,
    // Result items
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // [15:0] distance
    output logic      [apsp_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    // [0] is_inf, [1] done_res
    output logic      [apsp_pkg::M_TUSER_W-1:0]       m_axis_tuser
);

    logic [apsp_pkg::NODE_COUNT_W-1:0] node_count;
    logic [apsp_pkg::INF_W-1:0]        inf_value;
    apsp_pkg::op_t                     in_op;
    apsp_pkg::dp_cmd_t                 cmd;
    apsp_pkg::dp_status_t              status;
    logic                              out_is_inf;
    logic                              out_done;

    assign in_op = apsp_pkg::op_t'(s_axis_tuser);

    apsp_regs u_regs
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .node_count (node_count),
        .inf_value  (inf_value)
    );

    apsp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_op    (in_op),
        .status   (status),
        .cmd      (cmd)
    );

    apsp_dpath
    #(
        .MAX_NODES  (MAX_NODES),
        .DIST_WIDTH (DIST_WIDTH)
    )
    u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .node_count   (node_count),
        .inf_value    (inf_value),
        .in_op        (in_op),
        .in_src       (s_axis_tdata[apsp_pkg::SRC_LSB +: apsp_pkg::NODE_FIELD_W]),
        .in_dst       (s_axis_tdata[apsp_pkg::DST_LSB +: apsp_pkg::NODE_FIELD_W]),
        .in_weight    (s_axis_tdata[apsp_pkg::WEIGHT_LSB +: apsp_pkg::WEIGHT_W]),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_distance (m_axis_tdata),
        .out_is_inf   (out_is_inf),
        .out_done     (out_done)
    );

    assign m_axis_tuser = {out_done, out_is_inf};

`ifndef SYNTHESIS
    // Only one item in work: ready drops right after an accept.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("item accepted while another is in work");

    // The RAM is touched only while an item is in work.
    a_mem_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (cmd.mem_cmd == apsp_pkg::MEM_IDLE))
        else $error("memory access while idle");

    // A result is posted only into a free output register.
    a_post_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.post |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result overwrote a pending item");

    // Posting a result shows it and reopens the input in the next cycle.
    a_post_show: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.post |=> (m_axis_tvalid && s_axis_tready))
        else $error("posted result not presented");
`endif

endmodule

`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for all_pairs_shortest_path_top (Floyd-Warshall engine).
// Drives clear, edge, solve and read items and APB register writes, and compares every
// result item with an in-bench distance matrix. Needs apsp_pkg and the RTL under src/.
`timescale 1ns / 1ps

module testbench;

    // Block configuration under test (matches the RTL defaults).
    localparam int NODES  = 64;
    localparam int DIST_W = 16;

    // Result tuser bit positions.
    localparam int IS_INF_BIT = 0;
    localparam int DONE_BIT   = 1;

    // Receiver hold-off used to back the block up; pause after the last result
    // before touching registers; run limit. The limit covers one full 64-node
    // solve, a few dozen full-store clears, small solves and worst-case idling
    // on both sides, taken several times over.
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE      = 8;
    localparam int CYCLE_LIMIT = 6_000_000;

    typedef struct packed
    {
        logic [DIST_W-1:0] distance;
        logic              is_inf;
        logic              done_res;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [apsp_pkg::APB_ADDR_W-1:0]     paddr;
    logic [apsp_pkg::APB_DATA_W-1:0]     pwdata;
    logic [apsp_pkg::APB_DATA_W-1:0]     prdata;
    logic                                pready;

    logic                                s_axis_tvalid;
    logic                                s_axis_tready;
    // [5:0] src_node, [11:6] dst_node, [27:12] edge_weight, [31:28] zero
    logic [apsp_pkg::S_TDATA_W-1:0]      s_axis_tdata;
    // [1:0] opcode
    logic [apsp_pkg::S_TUSER_W-1:0]      s_axis_tuser;

    logic                                m_axis_tvalid;
    logic                                m_axis_tready;
    // [15:0] distance
    logic [apsp_pkg::M_TDATA_W-1:0]      m_axis_tdata;
    // [0] is_inf, [1] done_res
    logic [apsp_pkg::M_TUSER_W-1:0]      m_axis_tuser;

    // Shadow of the block: distance store plus the two registers.
    logic [DIST_W-1:0]                   model_dist [NODES][NODES];
    logic [apsp_pkg::NODE_COUNT_W-1:0]   cfg_nodes;
    logic [apsp_pkg::INF_W-1:0]          cfg_inf;

    // Answers still owed by the block, oldest first.
    answer_t pending_answers[$];

    // Run state shared between the stimulus, the result sink and the watchdog.
    bit gaps_on      = 1'b1;
    bit hold_request = 1'b0;
    int fail_count      = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int solves_sent     = 0;
    int long_holds      = 0;
    int cycle_count     = 0;

    all_pairs_shortest_path_top
    #(
        .MAX_NODES  (NODES),
        .DIST_WIDTH (DIST_W)
    )
    dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost result ends here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles, %0d answers outstanding",
                   cycle_count, pending_answers.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Shadow update for one accepted item; returns the answer the block owes.
    // Counts above the store size saturate, and sums are formed one bit wider
    // so that two large distances never wrap into a short path.
    function automatic answer_t route_answer(apsp_pkg::op_t op, logic [5:0] src,
                                             logic [5:0] dst, logic [15:0] weight);
        int            n;
        logic [DIST_W:0] via;
        answer_t       ans;
        n = (cfg_nodes > NODES) ? NODES : int'(cfg_nodes);
        ans.distance = '0;
        ans.is_inf   = 1'b0;
        ans.done_res = 1'b1;
        case (op)
            apsp_pkg::OP_CLEAR:
            begin
                // whole store, not only the nodes in use
                for (int a = 0; a < NODES; a++)
                    for (int b = 0; b < NODES; b++)
                        model_dist[a][b] = (a == b) ? '0 : cfg_inf;
            end
            apsp_pkg::OP_EDGE:
            begin
                // self-loops and nodes out of use leave the store alone
                if (src < n && dst < n && src != dst)
                    model_dist[src][dst] = (weight > cfg_inf) ? cfg_inf : weight;
            end
            apsp_pkg::OP_SOLVE:
            begin
                for (int k = 0; k < n; k++)
                    for (int i = 0; i < n; i++)
                        for (int j = 0; j < n; j++)
                        begin
                            via = {1'b0, model_dist[i][k]} + {1'b0, model_dist[k][j]};
                            if (via < {1'b0, model_dist[i][j]})
                                model_dist[i][j] = via[DIST_W-1:0];
                        end
            end
            default:
            begin
                ans.distance = (src < n && dst < n) ? model_dist[src][dst] : cfg_inf;
                ans.is_inf   = (ans.distance == cfg_inf);
            end
        endcase
        return ans;
    endfunction

    // Offers one item, optionally after an idle burst, and records its answer
    // once the block takes it. tvalid stays high on return so back-to-back
    // items keep the bus busy.
    task automatic issue_item(apsp_pkg::op_t op, logic [5:0] src, logic [5:0] dst,
                              logic [15:0] weight);
        logic [apsp_pkg::S_TDATA_W-1:0] word;
        word = '0;
        word[apsp_pkg::SRC_LSB +: apsp_pkg::NODE_FIELD_W]    = src;
        word[apsp_pkg::DST_LSB +: apsp_pkg::NODE_FIELD_W]    = dst;
        word[apsp_pkg::WEIGHT_LSB +: apsp_pkg::WEIGHT_W]     = weight;
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_answers.insert(pending_answers.size(), route_answer(op, src, dst, weight));
        items_sent++;
        if (op == apsp_pkg::OP_SOLVE)
            solves_sent++;
    endtask

    // Stops offering items and waits until every answer is in, plus a short
    // margin, so registers can be touched safely.
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // One APB transfer: setup, access, wait for pready, then return to idle.
    task automatic apb_transfer(bit wr, apsp_pkg::reg_idx_t idx,
                                logic [apsp_pkg::APB_DATA_W-1:0] wdata,
                                output logic [apsp_pkg::APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_register(apsp_pkg::reg_idx_t idx,
                                  logic [apsp_pkg::APB_DATA_W-1:0] want);
        logic [apsp_pkg::APB_DATA_W-1:0] got;
        apb_transfer(1'b0, idx, '0, got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", idx.name(), want, got);
            fail_count++;
        end
    endtask

    // Writes both registers, reads them back and updates the shadow copy.
    task automatic set_config(logic [apsp_pkg::NODE_COUNT_W-1:0] nodes,
                              logic [apsp_pkg::INF_W-1:0] inf);
        logic [apsp_pkg::APB_DATA_W-1:0] unused;
        apb_transfer(1'b1, apsp_pkg::REG_NODE_COUNT, apsp_pkg::APB_DATA_W'(nodes), unused);
        apb_transfer(1'b1, apsp_pkg::REG_INF_VALUE, apsp_pkg::APB_DATA_W'(inf), unused);
        check_register(apsp_pkg::REG_NODE_COUNT, apsp_pkg::APB_DATA_W'(nodes));
        check_register(apsp_pkg::REG_INF_VALUE, apsp_pkg::APB_DATA_W'(inf));
        cfg_nodes = nodes;
        cfg_inf   = inf;
    endtask

    // Mostly nodes in use, now and then any index (edge dropped, read gives inf).
    function automatic logic [5:0] pick_node(int span);
        if (span == 0 || $urandom_range(0, 7) == 0)
            return 6'($urandom);
        return 6'($urandom_range(0, span - 1));
    endfunction

    // Short weights so paths through pivots win; some zero, some full range.
    function automatic logic [15:0] pick_weight(logic [apsp_pkg::INF_W-1:0] inf);
        int r;
        int top;
        r   = $urandom_range(0, 15);
        top = (inf > 48) ? int'(inf) / 3 : 16;
        if (r == 0)
            return '0;
        if (r <= 2)
            return 16'($urandom);
        return 16'($urandom_range(1, top));
    endfunction

    // One random graph: new settings, clear (usually), one or two rounds of
    // edges, solve (small graphs only) and reads, with a sprinkle of arbitrary items.
    task automatic run_graph_phase();
        int                         r;
        int                         nodes;
        int                         span;
        int                         edge_cnt;
        logic [apsp_pkg::INF_W-1:0] inf;
        apsp_pkg::op_t              op;
        r = $urandom_range(0, 19);
        case (r)
            0:       nodes = 0;
            1:       nodes = 1;
            2:       nodes = $urandom_range(64, 127);
            3:       nodes = $urandom_range(13, 20);
            default: nodes = $urandom_range(2, 12);
        endcase
        r = $urandom_range(0, 15);
        if (r == 0)
            inf = '0;
        else if (r == 1)
            inf = '1;
        else if (r <= 4)
            inf = 16'($urandom);
        else
            inf = 16'($urandom_range(50, 2000));
        set_config(apsp_pkg::NODE_COUNT_W'(nodes), inf);
        span = (nodes > NODES) ? NODES : nodes;

        // skipping the clear now and then keeps stale entries under a new inf
        if ($urandom_range(0, 4) != 0)
            issue_item(apsp_pkg::OP_CLEAR, 6'($urandom), 6'($urandom), 16'($urandom));

        repeat ($urandom_range(1, 2))
        begin
            edge_cnt = $urandom_range(span, 3 * span + 2);
            if (edge_cnt > 40)
                edge_cnt = 40;
            repeat (edge_cnt)
            begin
                if ($urandom_range(0, 11) == 0)
                begin
                    // arbitrary item; a solve on a large graph becomes a read
                    op = apsp_pkg::op_t'($urandom_range(0, 3));
                    if (op == apsp_pkg::OP_SOLVE && span > 24)
                        op = apsp_pkg::OP_READ;
                    issue_item(op, 6'($urandom), 6'($urandom), 16'($urandom));
                end
                else
                    issue_item(apsp_pkg::OP_EDGE, pick_node(span), pick_node(span),
                               pick_weight(inf));
            end
            if (span <= 24)
                issue_item(apsp_pkg::OP_SOLVE, 6'($urandom), 6'($urandom), 16'($urandom));
            repeat ($urandom_range(4, 12))
                issue_item(apsp_pkg::OP_READ, pick_node(span), pick_node(span),
                           16'($urandom));
        end
        quiesce();
    endtask

    task automatic test_register_defaults();
        check_register(apsp_pkg::REG_NODE_COUNT,
                       apsp_pkg::APB_DATA_W'(apsp_pkg::NODE_COUNT_RESET));
        check_register(apsp_pkg::REG_INF_VALUE, apsp_pkg::APB_DATA_W'(apsp_pkg::INF_RESET));
    endtask

    // Small hand-built graph: overwrite, self-loop, weight capping, ignored
    // out-of-range edge, zero weight, inf+0 not beating inf, far-corner reads.
    task automatic test_directed_paths();
        set_config(7'd8, 16'd1000);
        issue_item(apsp_pkg::OP_CLEAR, 6'd0, 6'd0, 16'd0);
        issue_item(apsp_pkg::OP_READ, 6'd0, 6'd0, 16'd0);
        issue_item(apsp_pkg::OP_READ, 6'd0, 6'd7, 16'd0);
        issue_item(apsp_pkg::OP_EDGE, 6'd0, 6'd1, 16'd5);
        issue_item(apsp_pkg::OP_EDGE, 6'd0, 6'd1, 16'd4);
        issue_item(apsp_pkg::OP_EDGE, 6'd1, 6'd2, 16'd7);
        issue_item(apsp_pkg::OP_EDGE, 6'd0, 6'd2, 16'd20);
        issue_item(apsp_pkg::OP_EDGE, 6'd2, 6'd2, 16'd3);
        issue_item(apsp_pkg::OP_EDGE, 6'd2, 6'd3, 16'hFFFF);
        issue_item(apsp_pkg::OP_EDGE, 6'd63, 6'd0, 16'd1);
        issue_item(apsp_pkg::OP_EDGE, 6'd3, 6'd0, 16'd0);
        issue_item(apsp_pkg::OP_EDGE, 6'd7, 6'd6, 16'd999);
        issue_item(apsp_pkg::OP_READ, 6'd0, 6'd1, 16'hFFFF);
        issue_item(apsp_pkg::OP_SOLVE, 6'd63, 6'd63, 16'hFFFF);
        issue_item(apsp_pkg::OP_READ, 6'd0, 6'd2, 16'd0);
        issue_item(apsp_pkg::OP_READ, 6'd2, 6'd0, 16'd0);
        issue_item(apsp_pkg::OP_READ, 6'd2, 6'd2, 16'd0);
        issue_item(apsp_pkg::OP_READ, 6'd63, 6'd63, 16'd0);
        issue_item(apsp_pkg::OP_READ, 6'd0, 6'd63, 16'd0);
        issue_item(apsp_pkg::OP_READ, 6'd7, 6'd6, 16'd0);
        quiesce();
    endtask

    // Register extremes: one node, no nodes, inf of 0 and of 65535, a count
    // above the store size (one full-size solve), and exactly the store size.
    task automatic test_config_extremes();
        set_config(7'd1, 16'd1000);
        issue_item(apsp_pkg::OP_CLEAR, 6'd0, 6'd0, 16'd0);
        issue_item(apsp_pkg::OP_EDGE, 6'd0, 6'd0, 16'd5);
        issue_item(apsp_pkg::OP_EDGE, 6'd0, 6'd1, 16'd5);
        issue_item(apsp_pkg::OP_SOLVE, 6'd0, 6'd0, 16'd0);
        issue_item(apsp_pkg::OP_READ, 6'd0, 6'd0, 16'd0);
        issue_item(apsp_pkg::OP_READ, 6'd1, 6'd0, 16'd0);
        quiesce();

        set_config(7'd0, 16'd1000);
        issue_item(apsp_pkg::OP_EDGE, 6'd0, 6'd1, 16'd3);
        issue_item(apsp_pkg::OP_SOLVE, 6'd0, 6'd0, 16'd0);
        issue_item(apsp_pkg::OP_READ, 6'd0, 6'd0, 16'd0);
        quiesce();

        // inf of 0: every stored distance equals inf, so every read flags
        set_config(7'd4, 16'd0);
        issue_item(apsp_pkg::OP_CLEAR, 6'd0, 6'd0, 16'd0);
        issue_item(apsp_pkg::OP_EDGE, 6'd0, 6'd1, 16'd9);
        issue_item(apsp_pkg::OP_SOLVE, 6'd0, 6'd0, 16'd0);
        issue_item(apsp_pkg::OP_READ, 6'd0, 6'd1, 16'd0);
        issue_item(apsp_pkg::OP_READ, 6'd1, 6'd1, 16'd0);
        quiesce();

        // top of the range: sums past 16 bits must not wrap
        set_config(7'd4, 16'hFFFF);
        issue_item(apsp_pkg::OP_CLEAR, 6'd0, 6'd0, 16'd0);
        issue_item(apsp_pkg::OP_EDGE, 6'd0, 6'd1, 16'hFFFF);
        issue_item(apsp_pkg::OP_EDGE, 6'd1, 6'd2, 16'hFFFE);
        issue_item(apsp_pkg::OP_EDGE, 6'd2, 6'd3, 16'hFFFF);
        issue_item(apsp_pkg::OP_SOLVE, 6'd0, 6'd0, 16'd0);
        issue_item(apsp_pkg::OP_READ, 6'd0, 6'd2, 16'd0);
        issue_item(apsp_pkg::OP_READ, 6'd1, 6'd2, 16'd0);
        issue_item(apsp_pkg::OP_EDGE, 6'd0, 6'd1, 16'd1);
        issue_item(apsp_pkg::OP_SOLVE, 6'd0, 6'd0, 16'd0);
        issue_item(apsp_pkg::OP_READ, 6'd0, 6'd2, 16'd0);
        issue_item(apsp_pkg::OP_READ, 6'd0, 6'd3, 16'd0);
        quiesce();

        // 127 saturates to the full store: the one large solve of the run
        set_config(7'd127, 16'd1000);
        issue_item(apsp_pkg::OP_CLEAR, 6'd0, 6'd0, 16'd0);
        issue_item(apsp_pkg::OP_EDGE, 6'd0, 6'd63, 16'd10);
        issue_item(apsp_pkg::OP_EDGE, 6'd63, 6'd32, 16'd20);
        issue_item(apsp_pkg::OP_EDGE, 6'd32, 6'd1, 16'd30);
        issue_item(apsp_pkg::OP_EDGE, 6'd5, 6'd62, 16'hFFFF);
        issue_item(apsp_pkg::OP_SOLVE, 6'd0, 6'd0, 16'd0);
        issue_item(apsp_pkg::OP_READ, 6'd0, 6'd1, 16'd0);
        issue_item(apsp_pkg::OP_READ, 6'd0, 6'd32, 16'd0);
        issue_item(apsp_pkg::OP_READ, 6'd63, 6'd63, 16'd0);
        issue_item(apsp_pkg::OP_READ, 6'd5, 6'd62, 16'd0);
        quiesce();

        set_config(7'd64, 16'd1000);
        issue_item(apsp_pkg::OP_EDGE, 6'd63, 6'd0, 16'd77);
        issue_item(apsp_pkg::OP_READ, 6'd63, 6'd0, 16'd0);
        issue_item(apsp_pkg::OP_READ, 6'd63, 6'd1, 16'd0);
        quiesce();
    endtask

    task automatic test_random_graphs();
        int start;
        start = items_sent;
        while (items_sent - start < 600)
            run_graph_phase();
    endtask

    // Receiver stops for a long stretch while reads keep coming, so the
    // output register and the engine fill and s_axis_tready must drop.
    task automatic test_output_backpressure();
        set_config(7'd6, 16'd500);
        gaps_on      = 1'b0;
        hold_request = 1'b1;
        repeat (20)
            issue_item(apsp_pkg::OP_READ, pick_node(6), pick_node(6), 16'($urandom));
        quiesce();
        gaps_on = 1'b1;
    endtask

    // Last stretch with no idling on either side.
    task automatic test_steady_stream();
        int start;
        gaps_on = 1'b0;
        start   = items_sent;
        while (items_sent - start < 100)
            run_graph_phase();
    endtask

    // Result sink: checks every accepted result against the oldest answer,
    // then decides tready for the next cycle (random stalls or a long hold).
    initial
    begin
        int      stall_left;
        answer_t want;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready)
            begin
                if (pending_answers.size() == 0)
                begin
                    $error("result item with no request outstanding: distance %0d",
                           m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = pending_answers.pop_front();
                    results_checked++;
                    if (m_axis_tdata !== want.distance)
                    begin
                        $error("distance: expected %0d, got %0d", want.distance, m_axis_tdata);
                        fail_count++;
                    end
                    if (m_axis_tuser[IS_INF_BIT] !== want.is_inf)
                    begin
                        $error("is_inf: expected %0d, got %0d", want.is_inf,
                               m_axis_tuser[IS_INF_BIT]);
                        fail_count++;
                    end
                    if (m_axis_tuser[DONE_BIT] !== want.done_res)
                    begin
                        $error("done_res: expected %0d, got %0d", want.done_res,
                               m_axis_tuser[DONE_BIT]);
                        fail_count++;
                    end
                end
            end
            if (hold_request)
            begin
                stall_left   = LONG_HOLD;
                hold_request = 1'b0;
                long_holds++;
            end
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (gaps_on && $urandom_range(0, 6) == 0)
                    stall_left = $urandom_range(1, 12);
            end
        end
    end

    initial
    begin
        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= apsp_pkg::OP_CLEAR;
        cfg_nodes = apsp_pkg::NODE_COUNT_RESET;
        cfg_inf   = apsp_pkg::INF_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_defaults();
        // the first item after reset is a clear, so no entry is read unwritten
        test_directed_paths();
        test_config_extremes();
        test_random_graphs();
        test_output_backpressure();
        test_steady_stream();

        repeat (20) @(posedge clk);
        $display("Covered %0d items (%0d solves) and %0d checked results, %0d long output hold.",
                 items_sent, solves_sent, results_checked, long_holds);
        $display("Node counts 0 to 127 and infinity values 0 to 65535 were exercised.");
        if (fail_count == 0 && pending_answers.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### sim.f
src/apsp_pkg.sv
src/apsp_regs.sv
src/apsp_ctrl.sv
src/apsp_dpath.sv
src/all_pairs_shortest_path_top.sv
verif/testbench.sv
